/* rtl/core/spq_pkg.sv */
package spq_pkg;

    localparam int SPQ_CAPACITY      = 16;
    localparam int SPQ_PRIORITY_BITS = 8;
    localparam int SPQ_DATA_W        = 32;
    localparam int SPQ_PRIO_OUT_W    = 8;
    localparam int SPQ_COUNT_OUT_W   = 5;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } spq_cmd_t;

    typedef enum logic [1:0]
    {
        STATUS_OK           = 2'd0,
        STATUS_INSERT_FULL  = 2'd1,
        STATUS_REMOVE_EMPTY = 2'd2
    } spq_status_t;

    typedef struct packed
    {
        spq_cmd_t                command;
        logic signed [31:0]      item_data;
        logic [7:0]              item_priority;
    } spq_item_t;

    typedef struct packed
    {
        logic                    removed_valid;
        logic signed [31:0]      removed_data;
        logic [7:0]              removed_priority;
        logic signed [31:0]      front_data;
        logic [7:0]              front_priority;
        logic                    queue_empty;
        logic [4:0]              entry_count;
        spq_status_t             status;
    } spq_result_t;

    // per-cycle control broadcast to every cell
    typedef struct packed
    {
        logic insert_en;
        logic remove_en;
    } spq_ctl_t;

endpackage

/* rtl/core/spq_cell.sv */
module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIORITY_BITS = SPQ_PRIORITY_BITS
)
(
    input  logic                     clk,
    input  spq_ctl_t                 ctl,
    input  logic [SPQ_DATA_W-1:0]    new_data,
    input  logic [PRIORITY_BITS-1:0] new_prio,
    input  logic                     occupied,
    input  logic                     left_gt,
    input  logic [SPQ_DATA_W-1:0]    left_data,
    input  logic [PRIORITY_BITS-1:0] left_prio,
    input  logic [SPQ_DATA_W-1:0]    right_data,
    input  logic [PRIORITY_BITS-1:0] right_prio,
    output logic                     self_gt,
    output logic [SPQ_DATA_W-1:0]    data,
    output logic [PRIORITY_BITS-1:0] prio
);

    logic [SPQ_DATA_W-1:0]    data_reg;
    logic [SPQ_DATA_W-1:0]    data_next;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [PRIORITY_BITS-1:0] prio_next;

    // held entry strictly behind the new one: it moves down a place on insert
    assign self_gt = occupied && (prio_reg > new_prio);

    always_comb
    begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (ctl.remove_en)
        begin
            data_next = right_data;
            prio_next = right_prio;
        end
        else if (ctl.insert_en)
        begin
            if (left_gt)
            begin
                data_next = left_data;
                prio_next = left_prio;
            end
            else if (self_gt || !occupied)
            begin
                data_next = new_data;
                prio_next = new_prio;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign data = data_reg;
    assign prio = prio_reg;

endmodule

/* rtl/core/sorted_priority_queue_unit.sv */
// The result strobes on done in the cycle after start is taken.
// Throughput: one command per cycle; busy is never raised.
// Every cell compares its priority against the new one and shifts in
// parallel, so the chain length does not change the rate.
// Reset clears the count, the status and the strobe; cell contents stay as they are.
// The receiver cannot stall: done is high for a single cycle per result.
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY      = SPQ_CAPACITY,
    parameter int PRIORITY_BITS = SPQ_PRIORITY_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  spq_item_t   item,
    output logic        busy,
    output logic        done,
    output spq_result_t result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     done_reg;
    logic                     removed_valid_reg;
    logic [SPQ_DATA_W-1:0]    removed_data_reg;
    logic [PRIORITY_BITS-1:0] removed_prio_reg;
    spq_status_t              status_reg;
    spq_status_t              status_next;

    logic                     accept;
    logic                     full;
    logic                     empty;
    spq_ctl_t                 ctl;
    logic [PRIORITY_BITS-1:0] new_prio;
    logic [PRIORITY_BITS+7:0] new_prio_ext;

    logic [CAPACITY-1:0]      occ;
    logic [CAPACITY-1:0]      gt;
    logic [SPQ_DATA_W-1:0]    cell_data [CAPACITY];
    logic [PRIORITY_BITS-1:0] cell_prio [CAPACITY];

    logic [PRIORITY_BITS+7:0] front_prio_ext;
    logic [PRIORITY_BITS+7:0] removed_prio_ext;
    logic [CNT_W+4:0]         count_ext;

    assign busy         = 1'b0;
    assign accept       = start && !busy;
    assign full         = (count_reg == CNT_W'(CAPACITY));
    assign empty        = (count_reg == '0);
    assign new_prio_ext = {{PRIORITY_BITS{1'b0}}, item.item_priority};
    assign new_prio     = new_prio_ext[PRIORITY_BITS-1:0];

    always_comb
    begin
        ctl.insert_en = 1'b0;
        ctl.remove_en = 1'b0;
        count_next    = count_reg;
        status_next   = STATUS_OK;
        unique case (item.command)
            CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = STATUS_INSERT_FULL;
                end
                else
                begin
                    ctl.insert_en = accept;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (empty)
                begin
                    status_next = STATUS_REMOVE_EMPTY;
                end
                else
                begin
                    ctl.remove_en = accept;
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                     l_gt;
            logic [SPQ_DATA_W-1:0]    l_data;
            logic [PRIORITY_BITS-1:0] l_prio;
            logic [SPQ_DATA_W-1:0]    r_data;
            logic [PRIORITY_BITS-1:0] r_prio;

            assign occ[i] = (CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign l_gt   = 1'b0;
                assign l_data = '0;
                assign l_prio = '0;
            end
            else
            begin : g_body
                assign l_gt   = gt[i-1];
                assign l_data = cell_data[i-1];
                assign l_prio = cell_prio[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign r_data = '0;
                assign r_prio = '0;
            end
            else
            begin : g_mid
                assign r_data = cell_data[i+1];
                assign r_prio = cell_prio[i+1];
            end

            spq_cell #(
                .PRIORITY_BITS (PRIORITY_BITS)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .new_data   (item.item_data),
                .new_prio   (new_prio),
                .occupied   (occ[i]),
                .left_gt    (l_gt),
                .left_data  (l_data),
                .left_prio  (l_prio),
                .right_data (r_data),
                .right_prio (r_prio),
                .self_gt    (gt[i]),
                .data       (cell_data[i]),
                .prio       (cell_prio[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg  <= count_next;
                status_reg <= status_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_valid_reg <= ctl.remove_en;
            removed_data_reg  <= ctl.remove_en ? cell_data[0] : '0;
            removed_prio_reg  <= ctl.remove_en ? cell_prio[0] : '0;
        end
    end

    assign front_prio_ext   = {8'd0, cell_prio[0]};
    assign removed_prio_ext = {8'd0, removed_prio_reg};
    assign count_ext        = {5'd0, count_reg};

    assign done                    = done_reg;
    assign result.removed_valid    = removed_valid_reg;
    assign result.removed_data     = removed_data_reg;
    assign result.removed_priority = removed_prio_ext[7:0];
    assign result.front_data       = empty ? '0 : cell_data[0];
    assign result.front_priority   = empty ? '0 : front_prio_ext[7:0];
    assign result.queue_empty      = empty;
    assign result.entry_count      = count_ext[4:0];
    assign result.status           = status_reg;

endmodule

/* rtl/core/spq_checker.sv */
module spq_checker
    import spq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input spq_result_t result
);

    // a result only follows an accepted command
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("done without a transfer one cycle earlier");

    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.removed_valid) |-> (result.status == STATUS_OK))
        else $error("removal reported with error status");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.queue_empty == (result.entry_count == 5'd0)))
        else $error("empty flag disagrees with count");

    // dropped insert leaves the queue alone
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done) && result.status == STATUS_INSERT_FULL)
        |-> (result.entry_count == $past(result.entry_count)))
        else $error("count moved on a dropped insert");

    // the removed entry is the previous front
    a_remove_front: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done) && result.removed_valid)
        |-> (result.removed_data == $past(result.front_data)
             && result.removed_priority == $past(result.front_priority)))
        else $error("removed entry is not the previous front");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
